/* rtl/core/mgr_pkg.sv */
// Package for the gravity removal core: payload types, divider link types,
// fixed-point helpers. No dependencies.
`timescale 1ns / 1ps
package mgr_pkg;

	localparam int FracBits = 28;
	localparam int DivNumW  = 44;
	localparam int DivDenW  = 22;

	typedef enum logic [1:0] {
		CFG_TAU  = 2'd0,
		CFG_GRAV = 2'd1
	} cfg_idx_t;

	typedef struct packed {
		logic signed [15:0] quat_w;
		logic signed [15:0] quat_x;
		logic signed [15:0] quat_y;
		logic signed [15:0] quat_z;
		logic signed [23:0] accel_x;
		logic signed [23:0] accel_y;
		logic signed [23:0] accel_z;
		logic [15:0]        dt_us;
	} in_t;

	typedef struct packed {
		logic signed [23:0] motion_body_x;
		logic signed [23:0] motion_body_y;
		logic signed [23:0] motion_body_z;
		logic signed [23:0] motion_nav_x;
		logic signed [23:0] motion_nav_y;
		logic signed [23:0] motion_nav_z;
	} out_t;

	typedef struct packed {
		logic               start;
		logic [DivNumW-1:0] num;
		logic [DivDenW-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic [DivNumW-1:0] quot;
	} div_rsp_t;

	function automatic logic signed [33:0] rnd28(input logic signed [61:0] v);
		logic [61:0] m;
		logic [61:0] r;
		begin
			m = v[61] ? 62'(-v) : 62'(v);
			r = (m + (62'd1 << (FracBits - 1))) >> FracBits;
			rnd28 = v[61] ? -$signed(r[33:0]) : $signed(r[33:0]);
		end
	endfunction

	function automatic logic signed [23:0] sat24(input logic signed [47:0] v);
		begin
			if (v > 48'sd8388607)
				sat24 = 24'sh7fffff;
			else if (v < -48'sd8388608)
				sat24 = 24'sh800000;
			else
				sat24 = v[23:0];
		end
	endfunction

endpackage

/* rtl/core/mgr_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on mgr_pkg.
`timescale 1ns / 1ps
module mgr_div (
	input  logic              clk,
	input  logic              arst_n,
	input  mgr_pkg::div_req_t req,
	output mgr_pkg::div_rsp_t rsp
);
	logic [mgr_pkg::DivNumW-1:0] n_q;
	logic [mgr_pkg::DivDenW-1:0] d_q;
	logic [mgr_pkg::DivDenW-1:0] rem_q;
	logic [5:0]                  cnt_q;
	logic                        busy_q;
	logic                        done_q;
	logic [mgr_pkg::DivDenW:0]   trial;
	logic                        fits;

	assign trial = {rem_q, n_q[mgr_pkg::DivNumW-1]};
	assign fits  = trial >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'(mgr_pkg::DivNumW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			n_q   <= req.num;
			d_q   <= req.den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? mgr_pkg::DivDenW'(trial - {1'b0, d_q})
				: trial[mgr_pkg::DivDenW-1:0];
			n_q   <= {n_q[mgr_pkg::DivNumW-2:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = n_q;
endmodule

/* rtl/core/motion_accel_gravity_removal_core.sv */
// Top level of the gravity removal and motion low-pass core.
// Depends on mgr_pkg and mgr_div.
`timescale 1ns / 1ps
// An item runs through these steps from acceptance to its result. Nine quaternion products
// are formed, then the rotation matrix. Three gravity products follow. Then, per
// axis, one product and a 44-step division (one quotient bit a cycle) update the
// body motion. Nine matrix products follow, and the result is presented. All
// products run on one shared 35x27 multiplier. With tau plus dt equal to zero the
// divisions are skipped. The block is ready again in the same cycle in which the
// result is presented; it takes no new item before that. A result that is not taken
// holds the next item in the last state. A new item may be accepted while the
// previous result still waits.
module motion_accel_gravity_removal_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  mgr_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output mgr_pkg::out_t out_data,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [1:0]    cfg_index,
	input  logic [19:0]   cfg_data
);
	typedef enum logic [3:0] {
		S_IDLE, S_QMUL, S_RMAT, S_GMUL, S_GPOST, S_DMUL, S_DDIV, S_DWAIT,
		S_NMUL, S_NACC, S_NOUT, S_DONE
	} state_t;

	state_t state_q;
	logic [19:0] tau_q;
	logic [15:0] grav_q;
	mgr_pkg::in_t in_q;
	logic [20:0] den_q;
	logic [3:0] k_q;
	logic [1:0] i_q, j_q;
	logic signed [31:0] pr_q [9];
	logic signed [34:0] r_q [9];
	logic signed [23:0] m_q [3];
	logic signed [26:0] d_q [3];
	logic signed [23:0] nav_q [3];
	logic signed [61:0] acc_q;
	logic signed [61:0] mul_p_q;
	logic neg_q;
	logic out_valid_q;
	mgr_pkg::out_t out_q;
	logic signed [34:0] mul_a;
	logic signed [26:0] mul_b;
	logic signed [23:0] a_sel;
	mgr_pkg::div_req_t div_req;
	mgr_pkg::div_rsp_t div_rsp;
	logic [41:0] pmag;
	logic signed [33:0] gb;
	logic signed [47:0] m_new;
	logic [3:0] rij;

	mgr_div u_div (.clk(clk), .arst_n(arst_n), .req(div_req), .rsp(div_rsp));

	assign rij = 4'(i_q * 3) + 4'(j_q);
	assign a_sel = (i_q == 2'd0) ? in_q.accel_x : (i_q == 2'd1) ? in_q.accel_y : in_q.accel_z;
	assign gb = mgr_pkg::rnd28(mul_p_q);
	assign pmag = mul_p_q[61] ? 42'(-mul_p_q) : 42'(mul_p_q);
	assign m_new = 48'(m_q[i_q]) + (neg_q ? -$signed({4'd0, div_rsp.quot})
		: $signed({4'd0, div_rsp.quot}));

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_QMUL: begin
				case (k_q)
					4'd0: begin mul_a = 35'(in_q.quat_x); mul_b = 27'(in_q.quat_x); end
					4'd1: begin mul_a = 35'(in_q.quat_y); mul_b = 27'(in_q.quat_y); end
					4'd2: begin mul_a = 35'(in_q.quat_z); mul_b = 27'(in_q.quat_z); end
					4'd3: begin mul_a = 35'(in_q.quat_x); mul_b = 27'(in_q.quat_y); end
					4'd4: begin mul_a = 35'(in_q.quat_x); mul_b = 27'(in_q.quat_z); end
					4'd5: begin mul_a = 35'(in_q.quat_y); mul_b = 27'(in_q.quat_z); end
					4'd6: begin mul_a = 35'(in_q.quat_w); mul_b = 27'(in_q.quat_x); end
					4'd7: begin mul_a = 35'(in_q.quat_w); mul_b = 27'(in_q.quat_y); end
					default: begin mul_a = 35'(in_q.quat_w); mul_b = 27'(in_q.quat_z); end
				endcase
			end
			S_GMUL: begin
				mul_a = r_q[4'd6 + 4'(i_q)];
				mul_b = $signed({11'd0, grav_q});
			end
			S_DMUL: begin
				mul_a = 35'(d_q[i_q]);
				mul_b = $signed({11'd0, in_q.dt_us});
			end
			S_NMUL: begin
				mul_a = r_q[rij];
				mul_b = 27'(m_q[j_q]);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		mul_p_q <= mul_a * mul_b;
	end

	always_comb begin
		div_req.start = state_q == S_DDIV;
		div_req.num   = {1'b0, pmag, 1'b0} + 44'(den_q);
		div_req.den   = {den_q, 1'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			tau_q       <= 20'd8500;
			grav_q      <= 16'd10045;
			m_q         <= '{default: '0};
			out_valid_q <= 1'b0;
			k_q         <= '0;
			i_q         <= '0;
			j_q         <= '0;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == mgr_pkg::CFG_TAU)
					tau_q <= cfg_data;
				else if (cfg_index == mgr_pkg::CFG_GRAV)
					grav_q <= cfg_data[15:0];
			end
			if (out_valid_q && out_ready && state_q != S_DONE)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						in_q    <= in_data;
						den_q   <= 21'(tau_q) + 21'(in_data.dt_us);
						k_q     <= '0;
						state_q <= S_QMUL;
					end
				end
				S_QMUL: begin
					if (k_q != 4'd0)
						pr_q[k_q - 4'd1] <= mul_p_q[31:0];
					k_q <= k_q + 4'd1;
					if (k_q == 4'd9)
						state_q <= S_RMAT;
				end
				S_RMAT: begin
					r_q[0] <= (35'sd1 <<< 28) - 2 * (35'(pr_q[1]) + 35'(pr_q[2]));
					r_q[1] <= 2 * (35'(pr_q[3]) - 35'(pr_q[8]));
					r_q[2] <= 2 * (35'(pr_q[4]) + 35'(pr_q[7]));
					r_q[3] <= 2 * (35'(pr_q[3]) + 35'(pr_q[8]));
					r_q[4] <= (35'sd1 <<< 28) - 2 * (35'(pr_q[0]) + 35'(pr_q[2]));
					r_q[5] <= 2 * (35'(pr_q[5]) - 35'(pr_q[6]));
					r_q[6] <= 2 * (35'(pr_q[4]) - 35'(pr_q[7]));
					r_q[7] <= 2 * (35'(pr_q[5]) + 35'(pr_q[6]));
					r_q[8] <= (35'sd1 <<< 28) - 2 * (35'(pr_q[0]) + 35'(pr_q[1]));
					i_q     <= '0;
					state_q <= S_GMUL;
				end
				S_GMUL: state_q <= S_GPOST;
				S_GPOST: begin
					d_q[i_q] <= 27'(a_sel) - 27'(gb) - 27'(m_q[i_q]);
					if (i_q == 2'd2) begin
						i_q     <= '0;
						state_q <= (den_q == '0) ? S_NMUL : S_DMUL;
						j_q     <= '0;
						acc_q   <= '0;
					end else begin
						i_q     <= i_q + 2'd1;
						state_q <= S_GMUL;
					end
				end
				S_DMUL: state_q <= S_DDIV;
				S_DDIV: begin
					neg_q   <= mul_p_q[61];
					state_q <= S_DWAIT;
				end
				S_DWAIT: begin
					if (div_rsp.done) begin
						m_q[i_q] <= mgr_pkg::sat24(m_new);
						if (i_q == 2'd2) begin
							i_q     <= '0;
							j_q     <= '0;
							acc_q   <= '0;
							state_q <= S_NMUL;
						end else begin
							i_q     <= i_q + 2'd1;
							state_q <= S_DMUL;
						end
					end
				end
				S_NMUL: state_q <= S_NACC;
				S_NACC: begin
					acc_q <= acc_q + mul_p_q;
					if (j_q == 2'd2) begin
						state_q <= S_NOUT;
					end else begin
						j_q     <= j_q + 2'd1;
						state_q <= S_NMUL;
					end
				end
				S_NOUT: begin
					nav_q[i_q] <= mgr_pkg::sat24(48'(mgr_pkg::rnd28(acc_q)));
					acc_q <= '0;
					j_q   <= '0;
					if (i_q == 2'd2) begin
						state_q <= S_DONE;
					end else begin
						i_q     <= i_q + 2'd1;
						state_q <= S_NMUL;
					end
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						out_q <= '{motion_body_x: m_q[0], motion_body_y: m_q[1],
							motion_body_z: m_q[2], motion_nav_x: nav_q[0],
							motion_nav_y: nav_q[1], motion_nav_z: nav_q[2]};
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready  = state_q == S_IDLE;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready held after accepting an item");
	a_div_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == S_DWAIT)
		else $error("divider finished outside its wait");
	a_done_emits: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE && (!out_valid_q || out_ready) |=> out_valid_q)
		else $error("result not presented");
endmodule
